[rtl/round_robin_task_scheduler_core_assert.svh]
// Assertion macros for the round-robin task scheduler core.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_CORE_ASSERT_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_CORE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define RRTS_ASSERT_ALWAYS(label, ck, rn, cond, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define RRTS_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/rrts_pkg.sv]
// Package: types, codes and constants for the round-robin task scheduler.
`timescale 1ns / 1ps

package rrts_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int ADDR_W         = 4;
    localparam int DATA_W         = 32;
    localparam int IN_DATA_W      = 56;
    localparam int OUT_DATA_W     = 64;

    localparam logic [15:0] QUANTUM_RST    = 16'd10;
    localparam logic [15:0] STACK_TOP_RST  = 16'd2143;
    localparam logic [11:0] STACK_SIZE_RST = 12'd128;
    localparam logic [15:0] FRAME_DROP     = 16'd35;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_DELAY = 2'd1,
        OP_ADD   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        REG_QUANTUM    = 2'd0,
        REG_STACK_TOP  = 2'd1,
        REG_STACK_SIZE = 2'd2
    } reg_idx_t;

    // input word, lowest bits last
    typedef struct packed {
        logic [3:0]  pad;
        logic [15:0] current_stack_pointer;
        logic [31:0] delay_amount;
        logic [3:0]  process_id;
    } in_word_t;

    // result word, lowest bits last
    typedef struct packed {
        logic [6:0]  pad;
        logic [15:0] initial_stack_pointer;
        logic [15:0] frame_address;
        logic [2:0]  added_slot;
        logic        add_done;
        logic        none_ready;
        logic [15:0] next_stack_pointer;
        logic [2:0]  next_process;
        logic        switched;
    } res_word_t;

endpackage

[rtl/round_robin_task_scheduler_core.sv]
// Path: a taken word is held in the input register, then its result in the result register.
// Throughput: one word per cycle while the output is not stalled; the single compute stage updates the task table
// at the same edge it loads the result register.
// Reset (rst_n, async, low): pipeline empty, slot zero active, delays and quantum
// count zero, config to 10/2143/128; saved stack pointers are not cleared.
`timescale 1ns / 1ps
`include "round_robin_task_scheduler_core_assert.svh"

module round_robin_task_scheduler_core #(
    parameter int SLOT_COUNT = rrts_pkg::SLOT_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rrts_pkg::ADDR_W-1:0]    paddr,
    input  logic [rrts_pkg::DATA_W-1:0]    pwdata,
    output logic [rrts_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // process_id[3:0], delay_amount[35:4], current_stack_pointer[51:36], zero[55:52]
    input  logic [rrts_pkg::IN_DATA_W-1:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // switched[0], next_process[3:1], next_stack_pointer[19:4], none_ready[20],
    // add_done[21], added_slot[24:22], frame_address[40:25],
    // initial_stack_pointer[56:41], zero[63:57]
    output logic [rrts_pkg::OUT_DATA_W-1:0] m_tdata
);

    import rrts_pkg::*;

    localparam int IW = $clog2(SLOT_COUNT);

    typedef logic [IW-1:0] slot_t;

    // configuration
    logic [15:0] quantum_length_reg;
    logic [15:0] stack_top_reg;
    logic [11:0] stack_size_reg;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;

    // pipeline
    logic        in_valid_reg;
    in_word_t    in_word_reg;
    logic [1:0]  in_op_reg;
    logic        out_valid_reg;
    res_word_t   out_reg;
    logic        advance;

    // task table
    logic [SLOT_COUNT-1:0] slot_active_reg;
    logic [SLOT_COUNT-1:0] slot_active_next;
    logic [31:0]           delay_reg  [SLOT_COUNT];
    logic [31:0]           delay_next [SLOT_COUNT];
    logic [15:0]           saved_stack_reg [SLOT_COUNT];
    slot_t                 running_reg;
    slot_t                 running_next;
    logic [15:0]           quantum_reg;
    logic [15:0]           quantum_next;

    // compute stage
    op_t                   op;
    logic [15:0]           quantum_inc;
    logic                  pid_ok;
    slot_t                 pid_idx;
    logic                  do_switch;
    logic                  do_add;
    logic                  free_found;
    slot_t                 free_idx;
    logic [15:0]           frame;
    logic [15:0]           isp;
    logic [SLOT_COUNT-1:0] ready;
    slot_t                 pick_slot;
    logic                  pick_none;
    logic [15:0]           nsp;
    res_word_t             res_next;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_length_reg <= QUANTUM_RST;
            stack_top_reg      <= STACK_TOP_RST;
            stack_size_reg     <= STACK_SIZE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_QUANTUM:    quantum_length_reg <= pwdata[15:0];
                REG_STACK_TOP:  stack_top_reg      <= pwdata[15:0];
                REG_STACK_SIZE: stack_size_reg     <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_QUANTUM:    prdata = {16'd0, quantum_length_reg};
            REG_STACK_TOP:  prdata = {16'd0, stack_top_reg};
            REG_STACK_SIZE: prdata = {20'd0, stack_size_reg};
            default:        prdata = '0;
        endcase
    end

    // ---------------- stream handshake ----------------
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_word_reg <= in_word_t'(s_tdata);
            in_op_reg   <= s_tuser;
        end
        if (advance)
        begin
            out_reg <= res_next;
        end
    end

    // ---------------- compute ----------------
    assign op          = op_t'(in_op_reg);
    assign quantum_inc = quantum_reg + 16'd1;
    assign pid_ok      = {1'b0, in_word_reg.process_id} < 5'(SLOT_COUNT);
    assign pid_idx     = in_word_reg.process_id[IW-1:0];

    // first free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!slot_active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = slot_t'(i);
            end
        end
    end

    assign frame = stack_top_reg
                   - ({{(16-IW){1'b0}}, free_idx} * {4'd0, stack_size_reg});
    assign isp   = frame - FRAME_DROP;

    always_comb
    begin
        delay_next       = delay_reg;
        slot_active_next = slot_active_reg;
        quantum_next     = quantum_reg;
        do_switch        = 1'b0;
        do_add           = 1'b0;
        unique case (op)
            OP_TICK:
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (delay_reg[i] != 32'd0)
                    begin
                        delay_next[i] = delay_reg[i] - 32'd1;
                    end
                end
                quantum_next = quantum_inc;
                if (quantum_inc >= quantum_length_reg)
                begin
                    quantum_next = 16'd0;
                    do_switch    = 1'b1;
                end
            end
            OP_DELAY:
            begin
                if (pid_ok)
                begin
                    delay_next[pid_idx] = in_word_reg.delay_amount;
                end
                do_switch = 1'b1;
            end
            OP_ADD:
            begin
                do_add = free_found;
                if (free_found)
                begin
                    slot_active_next[free_idx] = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            ready[i] = slot_active_reg[i] && (delay_next[i] == 32'd0);
        end
    end

    rrts_pick #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_pick (
        .ready   (ready),
        .current (running_reg),
        .chosen  (pick_slot),
        .none    (pick_none)
    );

    // running slot's entry is overwritten by this switch
    assign nsp = (pick_slot == running_reg) ? in_word_reg.current_stack_pointer
                                            : saved_stack_reg[pick_slot];
    assign running_next = do_switch ? pick_slot : running_reg;

    always_comb
    begin
        res_next                       = '0;
        res_next.switched              = do_switch;
        res_next.next_process          = 3'(running_next);
        res_next.next_stack_pointer    = do_switch ? nsp : 16'd0;
        res_next.none_ready            = do_switch && pick_none;
        res_next.add_done              = do_add;
        res_next.added_slot            = do_add ? 3'(free_idx) : 3'd0;
        res_next.frame_address         = do_add ? frame : 16'd0;
        res_next.initial_stack_pointer = do_add ? isp : 16'd0;
    end

    // ---------------- state update ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_active_reg    <= SLOT_COUNT'(1);
            running_reg        <= '0;
            quantum_reg        <= '0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                delay_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            slot_active_reg <= slot_active_next;
            running_reg     <= running_next;
            quantum_reg     <= quantum_next;
            delay_reg       <= delay_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (do_switch)
            begin
                saved_stack_reg[running_reg] <= in_word_reg.current_stack_pointer;
            end
            if (do_add)
            begin
                saved_stack_reg[free_idx] <= isp;
            end
        end
    end

    // ---------------- assertions ----------------
    `RRTS_ASSERT_ALWAYS(a_running_active, clk, rst_n,
        slot_active_reg[running_reg],
        "running slot is not active")
    `RRTS_ASSERT_ALWAYS(a_none_needs_switch, clk, rst_n,
        !(out_valid_reg && out_reg.none_ready && !out_reg.switched),
        "none_ready without a switch")
    `RRTS_ASSERT_ALWAYS(a_add_no_switch, clk, rst_n,
        !(out_valid_reg && out_reg.switched && out_reg.add_done),
        "add and switch in one word")
    `RRTS_ASSERT_NEXT(a_pick_ready, clk, rst_n,
        advance && do_switch && !pick_none,
        delay_reg[running_reg] == 32'd0,
        "picked slot still delayed")
    `RRTS_ASSERT_NEXT(a_in_hold, clk, rst_n,
        in_valid_reg && !advance,
        in_valid_reg && $stable(in_word_reg),
        "held input word lost")

endmodule

[rtl/rrts_pick.sv]
// Rotating priority pick of the next ready slot after the running one.
`timescale 1ns / 1ps

module rrts_pick #(
    parameter int SLOT_COUNT = rrts_pkg::SLOT_COUNT_DEF
) (
    input  logic [SLOT_COUNT-1:0]         ready,
    input  logic [$clog2(SLOT_COUNT)-1:0] current,
    output logic [$clog2(SLOT_COUNT)-1:0] chosen,
    output logic                          none
);

    localparam int IW = $clog2(SLOT_COUNT);

    // nearest ready slot wins; current slot itself has the lowest priority
    always_comb
    begin
        logic [IW:0] sum;
        chosen = current;
        none   = 1'b1;
        sum    = '0;
        for (int k = SLOT_COUNT; k >= 1; k--)
        begin
            sum = {1'b0, current} + (IW+1)'(k);
            if (sum >= (IW+1)'(SLOT_COUNT))
            begin
                sum = sum - (IW+1)'(SLOT_COUNT);
            end
            if (ready[sum[IW-1:0]])
            begin
                chosen = sum[IW-1:0];
                none   = 1'b0;
            end
        end
    end

endmodule

[bench/tb_round_robin_task_scheduler_core.sv]
// Self-checking testbench for the round-robin task scheduler core: directed and random words.
`timescale 1ns / 1ps

module tb_round_robin_task_scheduler_core;
    import rrts_pkg::*;

    localparam int SLOTS = SLOT_COUNT_DEF;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic [1:0]  op;
        logic [3:0]  pid;
        logic [31:0] amount;
        logic [15:0] sp;
    } task_req_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [DATA_W-1:0]     pwdata = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // scheduler mirror
    logic [15:0] q_len;
    logic [15:0] s_top;
    logic [11:0] s_size;
    logic        slot_on [SLOTS];
    logic [31:0] wait_cnt [SLOTS];
    logic [15:0] sp_store [SLOTS];
    logic [2:0]  run_slot;
    logic [15:0] tick_cnt;

    task_req_t request_q [$];
    res_word_t decision_q [$];
    task_req_t cur_req;
    res_word_t want;
    res_word_t got;
    bit        steady = 1'b0;
    int        fail_count = 0;
    int        stall_cycles = 0;

    round_robin_task_scheduler_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic res_word_t run_scheduler(task_req_t rq);
        res_word_t   r;
        logic [15:0] frame;
        logic [2:0]  cur;
        logic [2:0]  s;
        logic        found;
        int          i;
        r = '0;
        found = 1'b0;
        case (rq.op)
            OP_TICK:
            begin
                for (i = 0; i < SLOTS; i++)
                    if (wait_cnt[i] != 0)
                        wait_cnt[i] = wait_cnt[i] - 32'd1;
                tick_cnt = tick_cnt + 16'd1;
                if (tick_cnt >= q_len)
                begin
                    tick_cnt = '0;
                    r.switched = 1'b1;
                end
            end
            OP_DELAY:
            begin
                if (rq.pid < SLOTS)
                    wait_cnt[rq.pid[2:0]] = rq.amount;
                r.switched = 1'b1;
            end
            OP_ADD:
            begin
                for (i = 0; i < SLOTS; i++)
                begin
                    if (!found && !slot_on[i])
                    begin
                        found = 1'b1;
                        frame = s_top - 16'(i * s_size);
                        slot_on[i] = 1'b1;
                        sp_store[i] = frame - FRAME_DROP;
                        r.add_done = 1'b1;
                        r.added_slot = 3'(i);
                        r.frame_address = frame;
                        r.initial_stack_pointer = frame - FRAME_DROP;
                    end
                end
            end
            default: ;
        endcase
        if (r.switched)
        begin
            cur = run_slot;
            sp_store[cur] = rq.sp;
            found = 1'b0;
            for (i = 1; i <= SLOTS; i++)
            begin
                s = cur + 3'(i);
                if (!found && slot_on[s] && wait_cnt[s] == 0)
                begin
                    found = 1'b1;
                    run_slot = s;
                end
            end
            r.none_ready = !found;
            r.next_stack_pointer = sp_store[run_slot];
        end
        r.next_process = run_slot;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    function automatic task_req_t make_req(int add_pct);
        task_req_t rq;
        int        r;
        r = $urandom_range(99);
        if (r < add_pct)
            rq.op = OP_ADD;
        else if (r < add_pct + 3)
            rq.op = OP_SPARE;
        else if (r < add_pct + 50)
            rq.op = OP_TICK;
        else
            rq.op = OP_DELAY;
        rq.pid = ($urandom_range(99) < 85) ? 4'($urandom_range(7)) : 4'($urandom_range(15, 8));
        r = $urandom_range(99);
        if (r < 70)
            rq.amount = $urandom_range(12);
        else if (r < 85)
            rq.amount = $urandom_range(200);
        else if (r < 95)
            rq.amount = $urandom;
        else
            rq.amount = 32'hFFFF_FFFF;
        rq.sp = 16'($urandom);
        return rq;
    endfunction

    task automatic push_req(logic [1:0] op, logic [3:0] pid, logic [31:0] amount,
                            logic [15:0] sp);
        task_req_t rq;
        rq.op = op;
        rq.pid = pid;
        rq.amount = amount;
        rq.sp = sp;
        request_q.push_back(rq);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        logic [31:0] junk;
        junk = $urandom;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        case (idx)
            REG_QUANTUM:
            begin
                pwdata <= {junk[31:16], value[15:0]};
                q_len = value[15:0];
            end
            REG_STACK_TOP:
            begin
                pwdata <= {junk[31:16], value[15:0]};
                s_top = value[15:0];
            end
            default:
            begin
                pwdata <= {junk[31:12], value[11:0]};
                s_size = value[11:0];
            end
        endcase
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (request_q.size() != 0 || s_tvalid || decision_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_phase(int count, int add_pct, bit first_add, bit calm);
        @(negedge clk);
        steady = calm;
        if (first_add)
            push_req(OP_ADD, 4'($urandom), $urandom, 16'($urandom));
        repeat (count) request_q.push_back(make_req(add_pct));
        wait_drained();
        steady = 1'b0;
    endtask

    // word source
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                decision_q.push_back(run_scheduler(cur_req));
            if (!s_tvalid || s_tready)
            begin
                if (request_q.size() != 0 && (steady || $urandom_range(99) >= 19))
                begin
                    cur_req = request_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {4'd0, cur_req.sp, cur_req.amount, cur_req.pid};
                    s_tuser <= cur_req.op;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result sink
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (decision_q.size() == 0)
            begin
                $error("result word with nothing pending");
                fail_count++;
            end
            else
            begin
                want = decision_q.pop_front();
                got = res_word_t'(m_tdata);
                check_field("switched", want.switched, got.switched);
                check_field("next_process", want.next_process, got.next_process);
                check_field("next_stack_pointer", want.next_stack_pointer,
                            got.next_stack_pointer);
                check_field("none_ready", want.none_ready, got.none_ready);
                check_field("add_done", want.add_done, got.add_done);
                check_field("added_slot", want.added_slot, got.added_slot);
                check_field("frame_address", want.frame_address, got.frame_address);
                check_field("initial_stack_pointer", want.initial_stack_pointer,
                            got.initial_stack_pointer);
            end
        end
        m_tready <= steady || ($urandom_range(99) >= 19);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            stall_cycles <= 0;
        else if (stall_cycles == STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        q_len = QUANTUM_RST;
        s_top = STACK_TOP_RST;
        s_size = STACK_SIZE_RST;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_on[i] = (i == 0);
            wait_cnt[i] = '0;
            sp_store[i] = '0;
        end
        run_slot = '0;
        tick_cnt = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset configuration
        @(negedge clk);
        push_req(OP_TICK, 4'd0, 32'd0, 16'h0000);
        push_req(OP_ADD, 4'd0, 32'd0, 16'h0000);
        push_req(OP_DELAY, 4'd0, 32'd0, 16'hFFFF);
        push_req(OP_DELAY, 4'd1, 32'hFFFF_FFFF, 16'h1234);
        // every slot delayed: nothing ready
        push_req(OP_DELAY, 4'd0, 32'd3, 16'hAAAA);
        push_req(OP_DELAY, 4'd15, 32'd5, 16'h5555);
        push_req(OP_DELAY, 4'd8, 32'd0, 16'h0000);
        push_req(OP_SPARE, 4'd15, 32'hFFFF_FFFF, 16'hFFFF);
        for (int i = 0; i < 9; i++)
            push_req(OP_TICK, 4'(i), 32'(i), 16'(i * 16'h1111));
        push_req(OP_ADD, 4'd3, 32'd9, 16'h0F0F);
        push_req(OP_DELAY, 4'd1, 32'd0, 16'hF0F0);
        push_req(OP_DELAY, 4'd7, 32'd1, 16'h00FF);
        push_req(OP_TICK, 4'd15, 32'hFFFF_FFFF, 16'hFFFF);
        push_req(OP_DELAY, 4'd2, 32'd2, 16'h8000);
        wait_drained();

        write_reg(REG_QUANTUM, 32'd1);
        write_reg(REG_STACK_TOP, 32'hFFFF);
        write_reg(REG_STACK_SIZE, 32'hFFF);
        run_phase(256, 1, 1'b1, 1'b0);

        // zero quantum: every tick switches
        write_reg(REG_QUANTUM, 32'd0);
        write_reg(REG_STACK_TOP, 32'd0);
        write_reg(REG_STACK_SIZE, 32'd0);
        run_phase(256, 1, 1'b1, 1'b0);

        write_reg(REG_QUANTUM, 32'hFFFF);
        write_reg(REG_STACK_TOP, $urandom);
        write_reg(REG_STACK_SIZE, $urandom);
        run_phase(256, 1, 1'b1, 1'b1);

        write_reg(REG_QUANTUM, $urandom_range(6, 2));
        write_reg(REG_STACK_TOP, 32'd2143);
        write_reg(REG_STACK_SIZE, 32'd128);
        run_phase(256, 1, 1'b1, 1'b0);

        // fill the table, then hit it full
        write_reg(REG_QUANTUM, $urandom_range(20, 1));
        write_reg(REG_STACK_SIZE, $urandom_range(4095));
        run_phase(256, 8, 1'b0, 1'b0);

        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
